/* hw/rtl/vcv_pkg.sv */
package vcv_pkg;

    // Fixed datapath widths
    localparam int CW           = 52;   // CORDIC x/y width
    localparam int ZW           = 20;   // CORDIC angle width
    localparam int CORDIC_STEPS = 17;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [63:0] NEAR_SQ     = 64'd10240000;   // 3200 squared
    localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
    localparam logic [19:0] PI_Q16      = 20'd205887;

    // Verdict codes
    localparam logic [2:0] VERDICT_FAR     = 3'd0;
    localparam logic [2:0] VERDICT_NEAR    = 3'd1;
    localparam logic [2:0] VERDICT_BEHIND  = 3'd2;
    localparam logic [2:0] VERDICT_OUTSIDE = 3'd3;
    localparam logic [2:0] VERDICT_INSIDE  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_CAM_X    = 3'd0;
    localparam logic [2:0] REG_CAM_Y    = 3'd1;
    localparam logic [2:0] REG_CAM_Z    = 3'd2;
    localparam logic [2:0] REG_FWD_X    = 3'd3;
    localparam logic [2:0] REG_FWD_Y    = 3'd4;
    localparam logic [2:0] REG_FWD_Z    = 3'd5;
    localparam logic [2:0] REG_MAX_DIST = 3'd6;
    localparam logic [2:0] REG_HALF_FOV = 3'd7;

    // One classified object as queued between front and back
    typedef struct packed {
        logic             bv;
        logic [2:0][32:0] d;     // test point minus camera, signed
        logic [2:0][32:0] emn;   // box minimum minus camera, signed
        logic [2:0][32:0] emx;   // box maximum minus camera, signed
        logic [2:0][30:0] ext;   // half box extent per axis
    } item_t;

    // Camera settings the back end needs
    typedef struct packed {
        logic [2:0][15:0] fwd;
        logic [30:0]      max_dist;
        logic [16:0]      half_fov;
    } cfg_t;

    function automatic logic [32:0] mag33(input logic [32:0] v);
        return v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd51472;
            5'd1:    r = 17'd30385;
            5'd2:    r = 17'd16055;
            5'd3:    r = 17'd8150;
            5'd4:    r = 17'd4091;
            5'd5:    r = 17'd2047;
            5'd6:    r = 17'd1024;
            5'd7:    r = 17'd512;
            5'd8:    r = 17'd256;
            5'd9:    r = 17'd128;
            5'd10:   r = 17'd64;
            5'd11:   r = 17'd32;
            5'd12:   r = 17'd16;
            5'd13:   r = 17'd8;
            5'd14:   r = 17'd4;
            5'd15:   r = 17'd2;
            5'd16:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/vcv_front.sv */
module vcv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         point_x,
    input  logic [31:0]         point_y,
    input  logic [31:0]         point_z,
    input  logic                bounds_valid,
    input  logic [31:0]         box_min_x,
    input  logic [31:0]         box_min_y,
    input  logic [31:0]         box_min_z,
    input  logic [31:0]         box_max_x,
    input  logic [31:0]         box_max_y,
    input  logic [31:0]         box_max_z,
    output vcv_pkg::cfg_t       cfg,
    output logic                push,
    input  logic                push_ready,
    output vcv_pkg::item_t      push_item
);
    import vcv_pkg::*;

    logic [2:0][31:0] cam_reg;
    logic [2:0][15:0] fwd_reg;
    logic [30:0]      max_dist_reg;
    logic [16:0]      half_fov_reg;
    logic             f_valid_reg;
    item_t            f_item_reg;
    item_t            item_next;
    logic [2:0][31:0] pt;
    logic [2:0][31:0] bmn;
    logic [2:0][31:0] bmx;
    logic [2:0][32:0] sum;
    logic [2:0][31:0] pc;
    logic [2:0][32:0] diff;
    logic [2:0][32:0] dmag;

    assign cfg_ready = 1'b1;
    assign cfg.fwd      = fwd_reg;
    assign cfg.max_dist = max_dist_reg;
    assign cfg.half_fov = half_fov_reg;

    assign pt  = {point_z, point_y, point_x};
    assign bmn = {box_min_z, box_min_y, box_min_x};
    assign bmx = {box_max_z, box_max_y, box_max_x};

    // Work out the test point and the camera-relative vectors per axis
    always_comb
    begin
        item_next.bv = bounds_valid;
        for (int i = 0; i < 3; i++)
        begin
            sum[i]  = {bmn[i][31], bmn[i]} + {bmx[i][31], bmx[i]};
            pc[i]   = bounds_valid ? sum[i][32:1] : pt[i];
            item_next.d[i]   = {pc[i][31], pc[i]} - {cam_reg[i][31], cam_reg[i]};
            item_next.emn[i] = {bmn[i][31], bmn[i]} - {cam_reg[i][31], cam_reg[i]};
            item_next.emx[i] = {bmx[i][31], bmx[i]} - {cam_reg[i][31], cam_reg[i]};
            diff[i] = {bmx[i][31], bmx[i]} - {bmn[i][31], bmn[i]};
            dmag[i] = mag33(diff[i]);
            item_next.ext[i] = dmag[i][31:1];
        end
    end

    assign in_ready  = !f_valid_reg || push_ready;
    assign push      = f_valid_reg;
    assign push_item = f_item_reg;

    // Hold the camera settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg      <= '0;
            fwd_reg      <= {16'd0, 16'd0, 16'd32767};
            max_dist_reg <= 31'd160000;
            half_fov_reg <= 17'd51472;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAM_X:    cam_reg[0]   <= cfg_data;
                REG_CAM_Y:    cam_reg[1]   <= cfg_data;
                REG_CAM_Z:    cam_reg[2]   <= cfg_data;
                REG_FWD_X:    fwd_reg[0]   <= cfg_data[15:0];
                REG_FWD_Y:    fwd_reg[1]   <= cfg_data[15:0];
                REG_FWD_Z:    fwd_reg[2]   <= cfg_data[15:0];
                REG_MAX_DIST: max_dist_reg <= cfg_data[30:0];
                REG_HALF_FOV: half_fov_reg <= cfg_data[16:0];
                default:      ;
            endcase
        end
    end

    // Capture a transaction, hand it to the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f_valid_reg <= in_valid;
            if (in_valid)
            begin
                f_item_reg <= item_next;
            end
        end
    end

endmodule

/* hw/rtl/vcv_queue.sv */
module vcv_queue #(
    parameter int DEPTH = vcv_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            push_ready,
    input  vcv_pkg::item_t  push_item,
    output logic            pop_valid,
    input  logic            pop,
    output vcv_pkg::item_t  pop_item
);
    import vcv_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CNTW-1:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/vcv_sqrt.sv */
module vcv_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] arg,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] n_reg;
    logic [32:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        fits;

    assign rem_sh = {rem_reg, n_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);
    assign done   = done_reg;
    assign root   = root_reg;

    // Two bits of radicand per cycle, one root bit out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= arg;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 5'd31;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                n_reg    <= {n_reg[61:0], 2'b00};
                rem_reg  <= fits ? 33'(rem_sh - trial) : rem_sh[32:0];
                root_reg <= {root_reg[30:0], fits};
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/vcv_cordic.sv */
module vcv_cordic (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           vec_mode,
    input  logic signed [vcv_pkg::CW-1:0]  x_in,
    input  logic signed [vcv_pkg::CW-1:0]  y_in,
    input  logic signed [vcv_pkg::ZW-1:0]  z_in,
    output logic                           done,
    output logic signed [vcv_pkg::CW-1:0]  x_out,
    output logic signed [vcv_pkg::CW-1:0]  y_out,
    output logic signed [vcv_pkg::ZW-1:0]  z_out
);
    import vcv_pkg::*;

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 mode_reg;
    logic [4:0]           i_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;
    logic                 plus;

    assign dx   = y_reg >>> i_reg;
    assign dy   = x_reg >>> i_reg;
    assign at   = signed'({3'b000, atan_q16(i_reg)});
    // Vectoring drives y to zero, rotation drives z to zero
    assign plus = mode_reg ? (y_reg > 0) : (z_reg < 0);

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= x_in;
                y_reg    <= y_in;
                z_reg    <= z_in;
                mode_reg <= vec_mode;
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (plus)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/vcv_back.sv */
module vcv_back (
    input  logic            clk,
    input  logic            rst_n,
    input  vcv_pkg::cfg_t   cfg,
    input  logic            pop_valid,
    output logic            pop,
    input  vcv_pkg::item_t  pop_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            in_view,
    output logic [2:0]      verdict
);
    import vcv_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RANGE, S_SQ, S_MAXSQ, S_TDOT, S_TESQ, S_TEVAL, S_TL0, S_TL1,
        S_TL2, S_TCMP, S_SQRT_D, S_DIV, S_QSQ, S_SQRT_S, S_ANG, S_HROT, S_HVEC,
        S_RSQ, S_SQRT_R, S_BANG, S_FINAL, S_DONE
    } state_t;

    state_t            state_reg;
    item_t             it_reg;
    logic [1:0]        idx_reg;
    logic [2:0]        k_reg;
    logic              corner_reg;
    logic [2:0][32:0]  e_reg;
    logic signed [50:0] dot_reg;
    logic signed [50:0] cdot_reg;
    logic [65:0]       esq_reg;
    logic [52:0]       a_reg;
    logic [105:0]      l_reg;
    logic [63:0]       d2_reg;
    logic [63:0]       r2_reg;
    logic [31:0]       dist_reg;
    logic [31:0]       div_rem_reg;
    logic [16:0]       div_num_reg;
    logic [16:0]       qv_reg;
    logic [4:0]        cnt_reg;
    logic signed [ZW-1:0] ang_reg;
    logic signed [ZW-1:0] lim_reg;
    logic signed [ZW-1:0] bang_reg;
    logic [2:0]        res_reg;
    logic              out_valid_reg;
    logic              in_view_reg;
    logic [2:0]        verdict_reg;

    logic              sq_start_reg;
    logic [63:0]       sq_arg_reg;
    logic              sq_done;
    logic [31:0]       sq_root;
    logic              cd_start_reg;
    logic              cd_mode_reg;
    logic signed [CW-1:0] cd_x_reg;
    logic signed [CW-1:0] cd_y_reg;
    logic signed [ZW-1:0] cd_z_reg;
    logic              cd_done;
    logic signed [CW-1:0] cd_x;
    logic signed [CW-1:0] cd_y;
    logic signed [ZW-1:0] cd_z;

    logic [32:0]       mul_a;
    logic [32:0]       mul_b;
    logic [65:0]       prod;
    logic [2:0][32:0]  d_mag;
    logic [2:0][32:0]  e_mag;
    logic [2:0][15:0]  f_mag;
    logic              too_far;
    logic [2:0]        ck;
    logic [2:0][32:0]  e_corner;
    logic              t_done;
    logic              t_pos;
    logic              t_neg;
    logic [105:0]      r_cmp;
    logic [48:0]       dot_abs;
    logic [48:0]       cdot_abs;
    logic              last_idx;
    logic [32:0]       div_sh;
    logic              div_fit;
    logic [16:0]       q_new;
    logic signed [23:0] lhs;
    logic signed [23:0] rhs;
    logic signed [ZW-1:0] h_s;
    logic signed [CW-1:0] nine_x;
    logic signed [CW-1:0] sixteen_y;

    vcv_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .arg   (sq_arg_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    vcv_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cd_start_reg),
        .vec_mode (cd_mode_reg),
        .x_in     (cd_x_reg),
        .y_in     (cd_y_reg),
        .z_in     (cd_z_reg),
        .done     (cd_done),
        .x_out    (cd_x),
        .y_out    (cd_y),
        .z_out    (cd_z)
    );

    assign pop       = (state_reg == S_IDLE) && pop_valid;
    assign out_valid = out_valid_reg;
    assign in_view   = in_view_reg;
    assign verdict   = verdict_reg;
    assign last_idx  = (idx_reg == 2'd2);
    assign h_s       = signed'({3'b000, cfg.half_fov});

    // Magnitudes and corner selection
    always_comb
    begin
        too_far = 1'b0;
        ck = corner_reg ? (k_reg + 3'd1) : 3'd0;
        for (int i = 0; i < 3; i++)
        begin
            d_mag[i] = mag33(it_reg.d[i]);
            e_mag[i] = mag33(e_reg[i]);
            f_mag[i] = cfg.fwd[i][15] ? (~cfg.fwd[i] + 16'd1) : cfg.fwd[i];
            e_corner[i] = ck[i] ? it_reg.emx[i] : it_reg.emn[i];
            if (d_mag[i] > {2'b00, cfg.max_dist})
            begin
                too_far = 1'b1;
            end
        end
    end

    // Select operands for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = d_mag[idx_reg];
                mul_b = d_mag[idx_reg];
            end
            S_MAXSQ:
            begin
                mul_a = {2'b00, cfg.max_dist};
                mul_b = {2'b00, cfg.max_dist};
            end
            S_TDOT:
            begin
                mul_a = e_mag[idx_reg];
                mul_b = {17'd0, f_mag[idx_reg]};
            end
            S_TESQ:
            begin
                mul_a = e_mag[idx_reg];
                mul_b = e_mag[idx_reg];
            end
            S_TL0:
            begin
                mul_a = {6'd0, a_reg[26:0]};
                mul_b = {6'd0, a_reg[26:0]};
            end
            S_TL1:
            begin
                mul_a = {7'd0, a_reg[52:27]};
                mul_b = {6'd0, a_reg[26:0]};
            end
            S_TL2:
            begin
                mul_a = {7'd0, a_reg[52:27]};
                mul_b = {7'd0, a_reg[52:27]};
            end
            S_QSQ:
            begin
                mul_a = {16'd0, qv_reg};
                mul_b = {16'd0, qv_reg};
            end
            S_RSQ:
            begin
                mul_a = {2'b00, it_reg.ext[idx_reg]};
                mul_b = {2'b00, it_reg.ext[idx_reg]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Sign of cos + 0.1 once it is known
    always_comb
    begin
        dot_abs  = dot_reg[50] ? 49'(-dot_reg) : dot_reg[48:0];
        cdot_abs = cdot_reg[50] ? 49'(-cdot_reg) : cdot_reg[48:0];
        r_cmp    = {10'd0, esq_reg, 30'd0};
        t_done   = 1'b0;
        t_pos    = 1'b0;
        t_neg    = 1'b0;
        if (state_reg == S_TEVAL)
        begin
            t_done = (esq_reg == '0) || !dot_reg[50];
            t_pos  = t_done;
        end
        else if (state_reg == S_TCMP)
        begin
            t_done = 1'b1;
            t_pos  = (l_reg < r_cmp);
            t_neg  = (l_reg > r_cmp);
        end
    end

    // Divider step and final compare
    always_comb
    begin
        div_sh  = {div_rem_reg, div_num_reg[16]};
        div_fit = (div_sh >= {1'b0, dist_reg});
        q_new   = {qv_reg[15:0], div_fit};
        if (q_new > 17'd32768)
        begin
            q_new = 17'd32768;
        end
        lhs       = 24'(ang_reg) <<< 1;
        rhs       = 24'(lim_reg) + (24'(lim_reg) <<< 1) + (24'(bang_reg) <<< 1);
        nine_x    = (cd_x <<< 3) + cd_x;
        sixteen_y = cd_y <<< 4;
    end

    // Sequencer for one object
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
            cd_start_reg  <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
            corner_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            sq_start_reg <= 1'b0;
            cd_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        it_reg    <= pop_item;
                        state_reg <= S_RANGE;
                    end
                end
                S_RANGE:
                begin
                    d2_reg  <= '0;
                    idx_reg <= '0;
                    if (too_far)
                    begin
                        res_reg   <= VERDICT_FAR;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    d2_reg  <= d2_reg + prod[63:0];
                    idx_reg <= idx_reg + 2'd1;
                    if (last_idx)
                    begin
                        state_reg <= S_MAXSQ;
                    end
                end
                S_MAXSQ:
                begin
                    if (d2_reg > prod[63:0])
                    begin
                        res_reg   <= VERDICT_FAR;
                        state_reg <= S_DONE;
                    end
                    else if (d2_reg < NEAR_SQ)
                    begin
                        res_reg   <= VERDICT_NEAR;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        e_reg      <= it_reg.d;
                        corner_reg <= 1'b0;
                        dot_reg    <= '0;
                        esq_reg    <= '0;
                        idx_reg    <= '0;
                        state_reg  <= S_TDOT;
                    end
                end
                S_TDOT:
                begin
                    if (e_reg[idx_reg][32] ^ cfg.fwd[idx_reg][15])
                    begin
                        dot_reg <= dot_reg - signed'({2'b00, prod[48:0]});
                    end
                    else
                    begin
                        dot_reg <= dot_reg + signed'({2'b00, prod[48:0]});
                    end
                    idx_reg <= idx_reg + 2'd1;
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_TESQ;
                    end
                end
                S_TESQ:
                begin
                    esq_reg <= esq_reg + prod;
                    idx_reg <= idx_reg + 2'd1;
                    if (last_idx)
                    begin
                        state_reg <= S_TEVAL;
                    end
                end
                S_TEVAL:
                begin
                    if (!corner_reg)
                    begin
                        cdot_reg <= dot_reg;
                    end
                    a_reg     <= {1'b0, dot_abs, 3'b000} + {3'b000, dot_abs, 1'b0};
                    state_reg <= S_TL0;
                end
                S_TL0:
                begin
                    l_reg     <= {52'd0, prod[53:0]};
                    state_reg <= S_TL1;
                end
                S_TL1:
                begin
                    l_reg     <= l_reg + {12'd0, prod[65:0], 28'd0};
                    state_reg <= S_TL2;
                end
                S_TL2:
                begin
                    l_reg     <= l_reg + {prod[51:0], 54'd0};
                    state_reg <= S_TCMP;
                end
                S_TCMP:
                begin
                    state_reg <= S_TCMP;
                end
                S_SQRT_D:
                begin
                    if (sq_done)
                    begin
                        dist_reg    <= sq_root;
                        div_rem_reg <= cdot_abs[48:17];
                        div_num_reg <= cdot_abs[16:0];
                        qv_reg      <= '0;
                        cnt_reg     <= 5'd16;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_rem_reg <= div_fit ? 32'(div_sh - {1'b0, dist_reg}) : div_sh[31:0];
                    div_num_reg <= {div_num_reg[15:0], 1'b0};
                    qv_reg      <= {qv_reg[15:0], div_fit};
                    cnt_reg     <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        qv_reg    <= q_new;
                        state_reg <= S_QSQ;
                    end
                end
                S_QSQ:
                begin
                    sq_arg_reg   <= (64'd1 << 30) - prod[63:0];
                    sq_start_reg <= 1'b1;
                    state_reg    <= S_SQRT_S;
                end
                S_SQRT_S:
                begin
                    if (sq_done)
                    begin
                        cd_x_reg     <= signed'({19'd0, qv_reg, 16'd0});
                        cd_y_reg     <= signed'({4'd0, sq_root, 16'd0});
                        cd_z_reg     <= '0;
                        cd_mode_reg  <= 1'b1;
                        cd_start_reg <= 1'b1;
                        state_reg    <= S_ANG;
                    end
                end
                S_ANG:
                begin
                    if (cd_done)
                    begin
                        if (cdot_reg[50] && (qv_reg != '0))
                        begin
                            ang_reg <= signed'(PI_Q16) - cd_z;
                        end
                        else
                        begin
                            ang_reg <= cd_z;
                        end
                        if (cfg.half_fov >= HALF_PI_Q16)
                        begin
                            lim_reg   <= h_s;
                            idx_reg   <= '0;
                            r2_reg    <= '0;
                            bang_reg  <= '0;
                            state_reg <= it_reg.bv ? S_RSQ : S_FINAL;
                        end
                        else
                        begin
                            cd_x_reg     <= signed'(CW'(1) << 24);
                            cd_y_reg     <= '0;
                            cd_z_reg     <= h_s;
                            cd_mode_reg  <= 1'b0;
                            cd_start_reg <= 1'b1;
                            state_reg    <= S_HROT;
                        end
                    end
                end
                S_HROT:
                begin
                    if (cd_done)
                    begin
                        cd_x_reg     <= nine_x;
                        cd_y_reg     <= sixteen_y;
                        cd_z_reg     <= '0;
                        cd_mode_reg  <= 1'b1;
                        cd_start_reg <= 1'b1;
                        state_reg    <= S_HVEC;
                    end
                end
                S_HVEC:
                begin
                    if (cd_done)
                    begin
                        lim_reg   <= (cd_z > h_s) ? cd_z : h_s;
                        idx_reg   <= '0;
                        r2_reg    <= '0;
                        bang_reg  <= '0;
                        state_reg <= it_reg.bv ? S_RSQ : S_FINAL;
                    end
                end
                S_RSQ:
                begin
                    r2_reg  <= r2_reg + prod[63:0];
                    idx_reg <= idx_reg + 2'd1;
                    if (last_idx)
                    begin
                        sq_arg_reg   <= r2_reg + prod[63:0];
                        sq_start_reg <= 1'b1;
                        state_reg    <= S_SQRT_R;
                    end
                end
                S_SQRT_R:
                begin
                    if (sq_done)
                    begin
                        cd_x_reg     <= signed'({4'd0, dist_reg, 16'd0});
                        cd_y_reg     <= signed'({4'd0, sq_root, 16'd0});
                        cd_z_reg     <= '0;
                        cd_mode_reg  <= 1'b1;
                        cd_start_reg <= 1'b1;
                        state_reg    <= S_BANG;
                    end
                end
                S_BANG:
                begin
                    if (cd_done)
                    begin
                        bang_reg  <= cd_z;
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    res_reg   <= (lhs <= rhs) ? VERDICT_INSIDE : VERDICT_OUTSIDE;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        verdict_reg   <= res_reg;
                        in_view_reg   <= (res_reg == VERDICT_NEAR) ||
                                         (res_reg == VERDICT_INSIDE);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Act on the front/behind outcome of the centre or a corner
            if (t_done)
            begin
                if (!corner_reg && !t_neg)
                begin
                    sq_arg_reg   <= d2_reg;
                    sq_start_reg <= 1'b1;
                    state_reg    <= S_SQRT_D;
                end
                else if (corner_reg && t_pos)
                begin
                    sq_arg_reg   <= d2_reg;
                    sq_start_reg <= 1'b1;
                    state_reg    <= S_SQRT_D;
                end
                else if ((!corner_reg && !it_reg.bv) || (corner_reg && (k_reg == 3'd7)))
                begin
                    res_reg   <= VERDICT_BEHIND;
                    state_reg <= S_DONE;
                end
                else
                begin
                    k_reg      <= ck;
                    corner_reg <= 1'b1;
                    e_reg      <= e_corner;
                    dot_reg    <= '0;
                    esq_reg    <= '0;
                    idx_reg    <= '0;
                    state_reg  <= S_TDOT;
                end
            end
        end
    end

endmodule

/* hw/rtl/view_cone_visibility_test.sv */
// View cone visibility test.
// Configuration: write register index and data on cfg_valid; cfg_ready is always
// high. Registers are camera position, forward vector, maximum distance and vertical
// half field of view; write them only while no object is in flight.
// Input: one object per in_valid/in_ready transaction (point, optional box).
// Output: one in_view/verdict transaction per object, in input order.
// Objects pass through an input register and a four-entry queue to a sequencer that
// shares one multiplier, a bit-serial square root and a 17-step CORDIC.
// Too-far and very-near objects finish after the range checks. Others go on to a
// front test that, for a boxed object whose centre is behind the camera, checks up
// to all eight box corners, and if in front to the angle test. From acceptance an
// object passes through the input register and the queue to the sequencer.
// The input side keeps accepting until the queue is full, independent of the sequencer.
// A result waits in the output register while out_ready is low; the sequencer stalls
// only when it finishes the next object before that result is taken.
// Reset clears the queue and output valid and loads the default camera settings.
module view_cone_visibility_test #(
    parameter int QUEUE_DEPTH = vcv_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] point_z,
    input  logic        bounds_valid,
    input  logic [31:0] box_min_x,
    input  logic [31:0] box_min_y,
    input  logic [31:0] box_min_z,
    input  logic [31:0] box_max_x,
    input  logic [31:0] box_max_y,
    input  logic [31:0] box_max_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        in_view,
    output logic [2:0]  verdict
);
    import vcv_pkg::*;

    cfg_t  cfg;
    logic  push;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop;
    item_t pop_item;

    vcv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .bounds_valid (bounds_valid),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_min_z    (box_min_z),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .box_max_z    (box_max_z),
        .cfg          (cfg),
        .push         (push),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    vcv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    vcv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_view   (in_view),
        .verdict   (verdict)
    );

endmodule

/* hw/rtl/vcv_checker.sv */
module vcv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       in_view,
    input logic [2:0] verdict
);
    import vcv_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(in_view))
        else $error("stalled result changed");

    // Pass flag follows the verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_view == ((verdict == VERDICT_NEAR) || (verdict == VERDICT_INSIDE))))
        else $error("in_view does not match verdict");

    // Only defined verdict codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict <= VERDICT_INSIDE))
        else $error("undefined verdict code");

    // Configuration is not back-pressured when a result first appears
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind view_cone_visibility_test vcv_checker u_vcv_checker (.*);

/* tb/view_cone_visibility_test_tb.sv */
module view_cone_visibility_test_tb;
    import vcv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] px, py, pz;
        logic        bv;
        logic [31:0] mnx, mny, mnz;
        logic [31:0] mxx, mxy, mxz;
    } object_t;

    typedef struct {
        logic       in_view;
        logic [2:0] verdict;
    } outcome_t;

    localparam longint ARC_STEP [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                          256, 128, 64, 32, 16, 8, 4, 2, 1};
    localparam longint PI_UNITS    = 205887;
    localparam longint QUARTER_ARC = 102944;
    localparam int     WATCHDOG    = 20000;

    logic        clk = 1'b1;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] point_x = '0, point_y = '0, point_z = '0;
    logic        bounds_valid = 1'b0;
    logic [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
    logic [31:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        in_view;
    logic [2:0]  verdict;

    // camera settings as the block should hold them
    longint          cam_x, cam_y, cam_z, fwd_x, fwd_y, fwd_z;
    longint unsigned max_dist, half_fov;

    object_t  pending_objs[$];
    outcome_t outcome_q[$];
    int       send_idle = 0;
    int       recv_stall = 0;
    int       fails = 0;
    int       quiet_cycles = 0;

    view_cone_visibility_test dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned umag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // exact sign of cos(e, fwd) + 0.1; zero vector counts as in front
    function automatic int front_sign(longint ex, longint ey, longint ez);
        longint           dot;
        longint unsigned  sq, m;
        logic [127:0]     rsum, lhs;
        dot = ex * fwd_x + ey * fwd_y + ez * fwd_z;
        if (ex == 0 && ey == 0 && ez == 0) return 1;
        if (dot >= 0) return 1;
        rsum = '0;
        sq = umag(ex) * umag(ex);
        rsum += {64'd0, sq};
        sq = umag(ey) * umag(ey);
        rsum += {64'd0, sq};
        sq = umag(ez) * umag(ez);
        rsum += {64'd0, sq};
        rsum = rsum << 30;
        m = umag(dot) * 64'd10;
        lhs = {64'd0, m} * {64'd0, m};
        if (lhs < rsum) return 1;
        if (lhs == rsum) return 0;
        return -1;
    endfunction

    function automatic longint arc_of(longint x, longint y);
        longint z = 0;
        longint dx, dy;
        for (int i = 0; i < 17; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += ARC_STEP[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ARC_STEP[i];
            end
        end
        return z;
    endfunction

    // larger of vertical and 16:9 horizontal half angle
    function automatic longint view_limit(longint h);
        longint x = 64'sd1 << 24;
        longint y = 0;
        longint z = h;
        longint dx, dy, hz;
        if (h >= QUARTER_ARC) return h;
        for (int i = 0; i < 17; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARC_STEP[i];
            end
            else
            begin
                x += dx; y -= dy; z += ARC_STEP[i];
            end
        end
        hz = arc_of(9 * x, 16 * y);
        return hz > h ? hz : h;
    endfunction

    function automatic logic [2:0] classify_object(object_t o);
        longint          mn[3], mx[3], p[3], d[3];
        longint          dot, ang, lim, bang, ex, ey, ez;
        longint unsigned d2, span, q, s, e, r2;
        logic            front;
        mn[0] = longint'($signed(o.mnx)); mn[1] = longint'($signed(o.mny));
        mn[2] = longint'($signed(o.mnz));
        mx[0] = longint'($signed(o.mxx)); mx[1] = longint'($signed(o.mxy));
        mx[2] = longint'($signed(o.mxz));
        p[0] = longint'($signed(o.px)); p[1] = longint'($signed(o.py));
        p[2] = longint'($signed(o.pz));
        if (o.bv)
            for (int i = 0; i < 3; i++) p[i] = (mn[i] + mx[i]) >>> 1;
        d[0] = p[0] - cam_x; d[1] = p[1] - cam_y; d[2] = p[2] - cam_z;
        for (int i = 0; i < 3; i++)
            if (umag(d[i]) > max_dist) return VERDICT_FAR;
        d2 = 0;
        for (int i = 0; i < 3; i++) d2 += umag(d[i]) * umag(d[i]);
        if (d2 > max_dist * max_dist) return VERDICT_FAR;
        if (d2 < 64'd10240000) return VERDICT_NEAR;
        // centre behind: rescue only through a box corner in front
        if (front_sign(d[0], d[1], d[2]) < 0)
        begin
            front = 1'b0;
            if (o.bv)
                for (int k = 0; k < 8; k++)
                begin
                    ex = (k[0] ? mx[0] : mn[0]) - cam_x;
                    ey = (k[1] ? mx[1] : mn[1]) - cam_y;
                    ez = (k[2] ? mx[2] : mn[2]) - cam_z;
                    if (!front && front_sign(ex, ey, ez) > 0) front = 1'b1;
                end
            if (!front) return VERDICT_BEHIND;
        end
        span = root_floor(d2);
        dot = d[0] * fwd_x + d[1] * fwd_y + d[2] * fwd_z;
        q = umag(dot) / span;
        if (q > 64'd32768) q = 64'd32768;
        s = root_floor((64'd1 << 30) - q * q);
        ang = arc_of(longint'(q << 16), longint'(s << 16));
        if (dot < 0 && q != 0) ang = PI_UNITS - ang;
        lim = view_limit(longint'(half_fov));
        bang = 0;
        if (o.bv)
        begin
            r2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                e = umag(mx[i] - mn[i]) >> 1;
                r2 += e * e;
            end
            bang = arc_of(longint'(span << 16), longint'(root_floor(r2) << 16));
        end
        return (2 * ang <= 3 * lim + 2 * bang) ? VERDICT_INSIDE : VERDICT_OUTSIDE;
    endfunction

    // driver: hold each transaction until accepted, then advance or idle
    always @(posedge clk or negedge rst_n)
    begin
        object_t  o;
        outcome_t r;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                o = '{point_x, point_y, point_z, bounds_valid, box_min_x, box_min_y,
                      box_min_z, box_max_x, box_max_y, box_max_z};
                r.verdict = classify_object(o);
                r.in_view = (r.verdict == VERDICT_NEAR || r.verdict == VERDICT_INSIDE);
                outcome_q.push_back(r);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_objs.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    o = pending_objs.pop_front();
                    point_x <= o.px; point_y <= o.py; point_z <= o.pz;
                    bounds_valid <= o.bv;
                    box_min_x <= o.mnx; box_min_y <= o.mny; box_min_z <= o.mnz;
                    box_max_x <= o.mxx; box_max_y <= o.mxy; box_max_z <= o.mxz;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t w;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result in_view=%0d verdict=%0d",
                             $time, in_view, verdict);
                    fails++;
                end
                else
                begin
                    w = outcome_q.pop_front();
                    if (in_view !== w.in_view)
                    begin
                        $display("%0t: in_view expected %0d actual %0d",
                                 $time, w.in_view, in_view);
                        fails++;
                    end
                    if (verdict !== w.verdict)
                    begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, w.verdict, verdict);
                        fails++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog: drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_CAM_X:    cam_x = longint'($signed(val));
            REG_CAM_Y:    cam_y = longint'($signed(val));
            REG_CAM_Z:    cam_z = longint'($signed(val));
            REG_FWD_X:    fwd_x = longint'($signed(val[15:0]));
            REG_FWD_Y:    fwd_y = longint'($signed(val[15:0]));
            REG_FWD_Z:    fwd_z = longint'($signed(val[15:0]));
            REG_MAX_DIST: max_dist = {33'd0, val[30:0]};
            REG_HALF_FOV: half_fov = {47'd0, val[16:0]};
            default:      ;
        endcase
    endtask

    task automatic load_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                               logic [31:0] md, logic [31:0] hf);
        write_reg(REG_CAM_X, cx);
        write_reg(REG_CAM_Y, cy);
        write_reg(REG_CAM_Z, cz);
        write_reg(REG_FWD_X, {{16{fx[15]}}, fx});
        write_reg(REG_FWD_Y, {{16{fy[15]}}, fy});
        write_reg(REG_FWD_Z, {{16{fz[15]}}, fz});
        write_reg(REG_MAX_DIST, md);
        write_reg(REG_HALF_FOV, hf);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint spread(longint r);
        return longint'($urandom_range(0, 32'(2 * r))) - r;
    endfunction

    // object near the camera at a random scale, box around it half the time
    function automatic object_t near_object();
        object_t o;
        longint  rng, cx, cy, cz, ex, ey, ez, t;
        longint  md;
        md = (max_dist > 64'd1073741823) ? 64'd1073741823 : longint'(max_dist);
        case ($urandom_range(4))
            0:       rng = 3000;
            1:       rng = 20000;
            2:       rng = md / 2 + 1;
            3:       rng = md + 1;
            default: rng = (2 * md > 1073741823) ? 1073741823 : 2 * md + 1;
        endcase
        cx = cam_x + spread(rng); cy = cam_y + spread(rng); cz = cam_z + spread(rng);
        o.px = 32'(cx); o.py = 32'(cy); o.pz = 32'(cz);
        o.bv = $urandom_range(1);
        ex = $urandom_range(0, 32'(rng / ($urandom_range(1) ? 2 : 16)));
        ey = $urandom_range(0, 32'(rng / 4));
        ez = $urandom_range(0, 32'(rng / 4));
        o.mnx = 32'(cx - ex); o.mny = 32'(cy - ey); o.mnz = 32'(cz - ez);
        o.mxx = 32'(cx + ex); o.mxy = 32'(cy + ey); o.mxz = 32'(cz + ez);
        if ($urandom_range(9) == 0)
        begin
            t = o.mnx; o.mnx = o.mxx; o.mxx = 32'(t);
        end
        if (!o.bv && $urandom_range(1))
        begin
            o.mnx = $urandom; o.mxy = $urandom; o.mnz = $urandom;
        end
        return o;
    endfunction

    function automatic object_t noise_object();
        object_t o;
        o = '{$urandom, $urandom, $urandom, 1'($urandom), $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
        return o;
    endfunction

    function automatic object_t obj(longint x, longint y, longint z, logic bv,
                                    longint ax, longint ay, longint az,
                                    longint bx, longint by, longint bz);
        object_t o;
        o = '{32'(x), 32'(y), 32'(z), bv, 32'(ax), 32'(ay), 32'(az),
              32'(bx), 32'(by), 32'(bz)};
        return o;
    endfunction

    task automatic drain_phase();
        do @(posedge clk);
        while (pending_objs.size() != 0 || in_valid || outcome_q.size() != 0);
    endtask

    initial
    begin
        real fxr, fyr, fzr, nrm;
        cam_x = 0; cam_y = 0; cam_z = 0;
        fwd_x = 32767; fwd_y = 0; fwd_z = 0;
        max_dist = 160000; half_fov = 51472;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed objects against the reset camera
        pending_objs.push_back(obj(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(3199, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(160000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(160001, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(100000, 100000, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(-50000, 1000, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(50000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(5000, 60000, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(5000, 60000, 7, 0, -1, -1, -1, -1, -1, -1));
        // behind centre rescued by a corner in front
        pending_objs.push_back(obj(0, 0, 0, 1, -60000, -2000, -2000, 20000, 2000, 2000));
        // behind centre with all corners behind
        pending_objs.push_back(obj(0, 0, 0, 1, -60000, -200, -200, -50000, 200, 200));
        // inverted box
        pending_objs.push_back(obj(0, 0, 0, 1, 50000, 9000, 900, 30000, 1000, -900));
        // box wide enough to widen the cone
        pending_objs.push_back(obj(0, 0, 0, 1, 10000, 20000, -500, 30000, 60000, 500));
        // exactly sideways and exactly at a tenth behind
        pending_objs.push_back(obj(0, 40000, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(-10000, 99499, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_objs.push_back(obj(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                                   32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_objs.push_back(obj(32'h80000000, 32'h80000000, 32'h80000000, 1,
                                   32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_objs.push_back(obj(0, 0, 0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        drain_phase();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 55; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 55; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            // camera settings: extremes first, then random poses
            case (ph)
                0: load_camera(32'h80000000, 32'h80000000, 32'h80000000,
                               16'h8000, 16'h0000, 16'h0000, 32'h7FFFFFFF, 32'd0);
                1: load_camera(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               16'h0000, 16'h7FFF, 16'h0000, 32'd0, 32'd102943);
                2: load_camera(32'd0, 32'd0, 32'd0, 16'h0000, 16'h0000, 16'h8000,
                               32'd160000, 32'h0001FFFF);
                3: load_camera(32'd0, 32'd0, 32'd0, 16'h7FFF, 16'h0000, 16'h0000,
                               32'd160000, 32'd51472);
                default:
                begin
                    fxr = real'(spread(1000)); fyr = real'(spread(1000));
                    fzr = real'(spread(1000));
                    nrm = $sqrt(fxr * fxr + fyr * fyr + fzr * fzr) + 0.001;
                    load_camera($urandom, $urandom, $urandom,
                                16'($rtoi(32767.0 * fxr / nrm)),
                                16'($rtoi(32767.0 * fyr / nrm)),
                                16'($rtoi(32767.0 * fzr / nrm)),
                                $urandom_range(3000, 2000000), $urandom_range(0, 102943));
                end
            endcase
            for (int n = 0; n < 45; n++)
                pending_objs.push_back(($urandom_range(9) == 0) ? noise_object()
                                                                : near_object());
            drain_phase();
        end

        repeat (400) @(posedge clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
